[rtl/ssps_pkg.sv]
package ssps_pkg;

    // Default capacity of the point set.
    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    // Stored keys are coordinates with the sign bit flipped (offset binary).
    localparam int KEY_W = 16;
    localparam logic [KEY_W-1:0] KEY_SIGN = {1'b1, {(KEY_W-1){1'b0}}};

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_APPEND = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_PRESENT = 3'd1,
        ST_ORDER   = 3'd2,
        ST_FULL    = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_ROW,
        S_RD_COL,
        S_APP_LAST,
        S_BS_ISSUE,
        S_BS_CMP,
        S_CHK_ROW,
        S_ROW_MISS,
        S_ROW_SH,
        S_ROW_SH_WR,
        S_ROW_OPEN,
        S_COL_START,
        S_APP_COL,
        S_CHK_COL,
        S_COL_MISS,
        S_COL_SH
    } t_state;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] row_coord;
        logic signed [15:0] col_coord;
        logic [5:0]         row_slot_in;
        logic [5:0]         col_slot_in;
    } t_cmd_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [5:0]         row_slot;
        logic [5:0]         col_slot;
        logic signed [15:0] row_value;
        logic signed [15:0] col_value;
        logic [6:0]         points_in_row;
        logic [6:0]         rows_in_use;
    } t_result;

    // Converts a stored key back to a signed coordinate.
    function automatic logic signed [15:0] key_to_coord(input logic [KEY_W-1:0] key);
        return $signed(key ^ KEY_SIGN);
    endfunction

    // Converts a signed coordinate to an ordered key.
    function automatic logic [KEY_W-1:0] coord_to_key(input logic signed [15:0] coord);
        return $unsigned(coord) ^ KEY_SIGN;
    endfunction

endpackage

[rtl/ssps_ram.sv]
module ssps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/ssps_ctrl.sv]
module ssps_ctrl #(
    parameter int MAX_ROWS = ssps_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = ssps_pkg::MAX_COLS_DEF,
    localparam int RAW = $clog2(MAX_ROWS),
    localparam int CAW = $clog2(MAX_COLS),
    localparam int RCW = $clog2(MAX_ROWS + 1),
    localparam int CCW = $clog2(MAX_COLS + 1),
    localparam int RW  = ssps_pkg::KEY_W + CCW + RAW,
    localparam int KW  = ssps_pkg::KEY_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  ssps_pkg::t_cmd_item   i_item,
    output logic                  o_busy,
    output ssps_pkg::t_result     o_res,
    output logic                  o_res_valid,
    output logic                  o_row_we,
    output logic [RAW-1:0]        o_row_waddr,
    output logic [RW-1:0]         o_row_wdata,
    output logic [RAW-1:0]        o_row_raddr,
    input  logic [RW-1:0]         i_row_rdata,
    output logic                  o_col_we,
    output logic [RAW+CAW-1:0]    o_col_waddr,
    output logic [KW-1:0]         o_col_wdata,
    output logic [RAW+CAW-1:0]    o_col_raddr,
    input  logic [KW-1:0]         i_col_rdata
);

    localparam int SW = (RCW > CCW) ? RCW : CCW;

    ssps_pkg::t_state  r_state, n_state;
    ssps_pkg::t_cmd    r_cmd, n_cmd;
    logic [5:0]        r_rs, n_rs, r_cs, n_cs;
    logic [KW-1:0]     r_rk, n_rk, r_ck, n_ck;
    logic [RCW-1:0]    r_total, n_total;
    logic [SW-1:0]     r_lo, n_lo, r_hi, n_hi, r_s, n_s;
    logic              r_on_cols, n_on_cols;
    logic [RAW-1:0]    r_r, n_r, r_phys, n_phys;
    logic [CCW-1:0]    r_n, n_n;
    ssps_pkg::t_result r_res, n_res;
    logic              r_res_valid, n_res_valid;

    // Row table entry fields and shared search terms.
    logic [KW-1:0]  w_rkey;
    logic [CCW-1:0] w_rcnt;
    logic [RAW-1:0] w_rphys;
    logic [SW:0]    w_sum;
    logic [SW-1:0]  w_mid, w_sm1;
    logic           w_more, w_bs_lt, w_rows_full, w_cols_full;
    ssps_pkg::t_cmd w_in_cmd;
    logic [KW-1:0]  w_in_rk, w_in_ck;
    logic           w_rd_norow, w_rd_nocol;

    assign w_rkey      = i_row_rdata[RW-1 -: KW];
    assign w_rcnt      = i_row_rdata[RAW +: CCW];
    assign w_rphys     = i_row_rdata[RAW-1:0];
    assign w_sum       = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid       = w_sum[SW:1];
    assign w_sm1       = r_s - SW'(1);
    assign w_more      = r_lo < r_hi;
    assign w_bs_lt     = r_on_cols ? (i_col_rdata < r_ck) : (w_rkey < r_rk);
    assign w_rows_full = 32'(r_total) >= 32'(MAX_ROWS);
    assign w_cols_full = 32'(r_n) >= 32'(MAX_COLS);
    assign w_in_cmd    = ssps_pkg::t_cmd'(i_item.cmd);
    assign w_in_rk     = ssps_pkg::coord_to_key(i_item.row_coord);
    assign w_in_ck     = ssps_pkg::coord_to_key(i_item.col_coord);
    assign w_rd_norow  = (32'(i_item.row_slot_in) >= 32'(r_total))
                      || (32'(i_item.row_slot_in) >= 32'(MAX_ROWS));
    assign w_rd_nocol  = (32'(r_cs) >= 32'(w_rcnt)) || (32'(r_cs) >= 32'(MAX_COLS));

    // Registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssps_pkg::S_IDLE;
            r_total     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_res_valid <= n_res_valid;
        end
        r_cmd     <= n_cmd;
        r_rs      <= n_rs;
        r_cs      <= n_cs;
        r_rk      <= n_rk;
        r_ck      <= n_ck;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_s       <= n_s;
        r_on_cols <= n_on_cols;
        r_r       <= n_r;
        r_phys    <= n_phys;
        r_n       <= n_n;
        r_res     <= n_res;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ssps_pkg::S_IDLE: begin
                if (i_start) begin
                    unique case (w_in_cmd)
                        ssps_pkg::CMD_CLEAR:  n_state = ssps_pkg::S_IDLE;
                        ssps_pkg::CMD_READ:
                            n_state = w_rd_norow ? ssps_pkg::S_IDLE : ssps_pkg::S_RD_ROW;
                        ssps_pkg::CMD_APPEND:
                            n_state = (r_total == '0) ? ssps_pkg::S_ROW_OPEN
                                                      : ssps_pkg::S_APP_LAST;
                        ssps_pkg::CMD_INSERT: n_state = ssps_pkg::S_BS_ISSUE;
                    endcase
                end
            end
            ssps_pkg::S_RD_ROW:
                n_state = w_rd_nocol ? ssps_pkg::S_IDLE : ssps_pkg::S_RD_COL;
            ssps_pkg::S_RD_COL: n_state = ssps_pkg::S_IDLE;
            ssps_pkg::S_APP_LAST: begin
                priority if (w_rkey < r_rk) begin
                    n_state = w_rows_full ? ssps_pkg::S_IDLE : ssps_pkg::S_ROW_OPEN;
                end else begin
                    n_state = ssps_pkg::S_BS_ISSUE;
                end
            end
            ssps_pkg::S_BS_ISSUE: begin
                priority if (w_more) begin
                    n_state = ssps_pkg::S_BS_CMP;
                end else if (!r_on_cols) begin
                    n_state = (r_lo < SW'(r_total)) ? ssps_pkg::S_CHK_ROW
                                                    : ssps_pkg::S_ROW_MISS;
                end else begin
                    n_state = (r_lo < SW'(r_n)) ? ssps_pkg::S_CHK_COL
                                                : ssps_pkg::S_COL_MISS;
                end
            end
            ssps_pkg::S_BS_CMP: n_state = ssps_pkg::S_BS_ISSUE;
            ssps_pkg::S_CHK_ROW:
                n_state = (w_rkey == r_rk) ? ssps_pkg::S_COL_START : ssps_pkg::S_ROW_MISS;
            ssps_pkg::S_ROW_MISS:
                n_state = w_rows_full ? ssps_pkg::S_IDLE : ssps_pkg::S_ROW_SH;
            ssps_pkg::S_ROW_SH:
                n_state = (r_s > r_lo) ? ssps_pkg::S_ROW_SH_WR : ssps_pkg::S_ROW_OPEN;
            ssps_pkg::S_ROW_SH_WR: n_state = ssps_pkg::S_ROW_SH;
            ssps_pkg::S_ROW_OPEN: n_state = ssps_pkg::S_COL_START;
            ssps_pkg::S_COL_START: begin
                priority if (r_cmd == ssps_pkg::CMD_APPEND) begin
                    n_state = (r_n != '0) ? ssps_pkg::S_APP_COL : ssps_pkg::S_COL_MISS;
                end else begin
                    n_state = ssps_pkg::S_BS_ISSUE;
                end
            end
            ssps_pkg::S_APP_COL:
                n_state = (r_ck <= i_col_rdata) ? ssps_pkg::S_IDLE : ssps_pkg::S_COL_MISS;
            ssps_pkg::S_CHK_COL:
                n_state = (i_col_rdata == r_ck) ? ssps_pkg::S_IDLE : ssps_pkg::S_COL_MISS;
            ssps_pkg::S_COL_MISS:
                n_state = w_cols_full ? ssps_pkg::S_IDLE : ssps_pkg::S_COL_SH;
            // Shifting columns alternates read and write through r_on_cols.
            ssps_pkg::S_COL_SH: begin
                priority if (r_s > r_lo) begin
                    n_state = ssps_pkg::S_COL_SH;
                end else begin
                    n_state = ssps_pkg::S_IDLE;
                end
            end
            default: n_state = ssps_pkg::S_IDLE;
        endcase
    end

    // Datapath, memory control and result.
    always_comb begin
        n_cmd       = r_cmd;
        n_rs        = r_rs;
        n_cs        = r_cs;
        n_rk        = r_rk;
        n_ck        = r_ck;
        n_total     = r_total;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_s         = r_s;
        n_on_cols   = r_on_cols;
        n_r         = r_r;
        n_phys      = r_phys;
        n_n         = r_n;
        n_res       = r_res;
        n_res_valid = 1'b0;
        o_row_we    = 1'b0;
        o_row_waddr = r_lo[RAW-1:0];
        o_row_wdata = {r_rk, r_n, r_phys};
        o_row_raddr = r_lo[RAW-1:0];
        o_col_we    = 1'b0;
        o_col_waddr = {r_phys, r_s[CAW-1:0]};
        o_col_wdata = i_col_rdata;
        o_col_raddr = {r_phys, w_sm1[CAW-1:0]};
        unique case (r_state)
            ssps_pkg::S_IDLE: begin
                if (i_start) begin
                    n_cmd     = w_in_cmd;
                    n_rs      = i_item.row_slot_in;
                    n_cs      = i_item.col_slot_in;
                    n_rk      = w_in_rk;
                    n_ck      = w_in_ck;
                    n_lo      = '0;
                    n_hi      = SW'(r_total);
                    n_on_cols = 1'b0;
                    o_row_raddr = (r_total == '0) ? '0 : RAW'(r_total - RCW'(1));
                    unique case (w_in_cmd)
                        ssps_pkg::CMD_CLEAR: begin
                            n_total     = '0;
                            n_res_valid = 1'b1;
                            n_res       = '{ssps_pkg::ST_ADDED, '0, '0, '0, '0, '0, '0};
                        end
                        ssps_pkg::CMD_READ: begin
                            o_row_raddr = RAW'(i_item.row_slot_in);
                            if (w_rd_norow) begin
                                n_res_valid = 1'b1;
                                n_res = '{ssps_pkg::ST_EMPTY, i_item.row_slot_in,
                                          i_item.col_slot_in, '0, '0, '0, 7'(r_total)};
                            end
                        end
                        ssps_pkg::CMD_APPEND: begin
                            n_lo = SW'(r_total);
                        end
                        ssps_pkg::CMD_INSERT: begin
                            n_lo = '0;
                        end
                    endcase
                end
            end
            ssps_pkg::S_RD_ROW: begin
                n_rk        = w_rkey;
                n_n         = w_rcnt;
                o_col_raddr = {w_rphys, r_cs[CAW-1:0]};
                if (w_rd_nocol) begin
                    n_res_valid = 1'b1;
                    n_res = '{ssps_pkg::ST_EMPTY, r_rs, r_cs, ssps_pkg::key_to_coord(w_rkey),
                              '0, 7'(w_rcnt), 7'(r_total)};
                end
            end
            ssps_pkg::S_RD_COL: begin
                n_res_valid = 1'b1;
                n_res = '{ssps_pkg::ST_ADDED, r_rs, r_cs, ssps_pkg::key_to_coord(r_rk),
                          ssps_pkg::key_to_coord(i_col_rdata), 7'(r_n), 7'(r_total)};
            end
            ssps_pkg::S_APP_LAST: begin
                priority if (w_rkey < r_rk) begin
                    if (w_rows_full) begin
                        n_res_valid = 1'b1;
                        n_res = '{ssps_pkg::ST_FULL, '0, '0, ssps_pkg::key_to_coord(r_rk),
                                  ssps_pkg::key_to_coord(r_ck), '0, 7'(r_total)};
                    end
                end else begin
                    n_lo = '0;
                    n_hi = SW'(r_total);
                end
            end
            ssps_pkg::S_BS_ISSUE: begin
                priority if (w_more) begin
                    o_row_raddr = w_mid[RAW-1:0];
                    o_col_raddr = {r_phys, w_mid[CAW-1:0]};
                end else begin
                    o_row_raddr = r_lo[RAW-1:0];
                    o_col_raddr = {r_phys, r_lo[CAW-1:0]};
                end
            end
            ssps_pkg::S_BS_CMP: begin
                if (w_bs_lt) begin
                    n_lo = w_mid + SW'(1);
                end else begin
                    n_hi = w_mid;
                end
            end
            ssps_pkg::S_CHK_ROW: begin
                n_r    = r_lo[RAW-1:0];
                n_n    = w_rcnt;
                n_phys = w_rphys;
            end
            ssps_pkg::S_ROW_MISS: begin
                n_s = SW'(r_total);
                if (w_rows_full) begin
                    n_res_valid = 1'b1;
                    n_res = '{ssps_pkg::ST_FULL, '0, '0, ssps_pkg::key_to_coord(r_rk),
                              ssps_pkg::key_to_coord(r_ck), '0, 7'(r_total)};
                end
            end
            ssps_pkg::S_ROW_SH: begin
                o_row_raddr = w_sm1[RAW-1:0];
            end
            // Move one row table entry up by one slot.
            ssps_pkg::S_ROW_SH_WR: begin
                o_row_we    = 1'b1;
                o_row_waddr = r_s[RAW-1:0];
                o_row_wdata = i_row_rdata;
                n_s         = w_sm1;
            end
            // The new row takes the next free column block.
            ssps_pkg::S_ROW_OPEN: begin
                o_row_we    = 1'b1;
                o_row_waddr = r_lo[RAW-1:0];
                o_row_wdata = {r_rk, {CCW{1'b0}}, r_total[RAW-1:0]};
                n_r         = r_lo[RAW-1:0];
                n_n         = '0;
                n_phys      = r_total[RAW-1:0];
                n_total     = r_total + RCW'(1);
            end
            ssps_pkg::S_COL_START: begin
                o_col_raddr = {r_phys, CAW'(r_n - CCW'(1))};
                n_lo        = SW'(r_n);
                if (r_cmd != ssps_pkg::CMD_APPEND) begin
                    n_lo      = '0;
                    n_hi      = SW'(r_n);
                    n_on_cols = 1'b1;
                end
            end
            ssps_pkg::S_APP_COL: begin
                if (r_ck <= i_col_rdata) begin
                    n_res_valid = 1'b1;
                    n_res = '{ssps_pkg::ST_ORDER, 6'(r_r), '0, ssps_pkg::key_to_coord(r_rk),
                              ssps_pkg::key_to_coord(r_ck), 7'(r_n), 7'(r_total)};
                end
            end
            ssps_pkg::S_CHK_COL: begin
                if (i_col_rdata == r_ck) begin
                    n_res_valid = 1'b1;
                    n_res = '{ssps_pkg::ST_PRESENT, 6'(r_r), 6'(r_lo),
                              ssps_pkg::key_to_coord(r_rk), ssps_pkg::key_to_coord(r_ck),
                              7'(r_n), 7'(r_total)};
                end
            end
            ssps_pkg::S_COL_MISS: begin
                n_s       = SW'(r_n);
                n_on_cols = 1'b0;
                if (w_cols_full) begin
                    n_res_valid = 1'b1;
                    n_res = '{ssps_pkg::ST_FULL, 6'(r_r), '0, ssps_pkg::key_to_coord(r_rk),
                              ssps_pkg::key_to_coord(r_ck), 7'(r_n), 7'(r_total)};
                end
            end
            // r_on_cols low: read the entry below; high: write it one slot up.
            ssps_pkg::S_COL_SH: begin
                priority if (r_s > r_lo) begin
                    if (!r_on_cols) begin
                        o_col_raddr = {r_phys, w_sm1[CAW-1:0]};
                        n_on_cols   = 1'b1;
                    end else begin
                        o_col_we    = 1'b1;
                        o_col_waddr = {r_phys, r_s[CAW-1:0]};
                        o_col_wdata = i_col_rdata;
                        n_s         = w_sm1;
                        n_on_cols   = 1'b0;
                    end
                end else begin
                    o_col_we    = 1'b1;
                    o_col_waddr = {r_phys, r_lo[CAW-1:0]};
                    o_col_wdata = r_ck;
                    o_row_we    = 1'b1;
                    o_row_waddr = r_r;
                    o_row_wdata = {r_rk, r_n + CCW'(1), r_phys};
                    n_res_valid = 1'b1;
                    n_res = '{ssps_pkg::ST_ADDED, 6'(r_r), 6'(r_lo),
                              ssps_pkg::key_to_coord(r_rk), ssps_pkg::key_to_coord(r_ck),
                              7'(r_n + CCW'(1)), 7'(r_total)};
                end
            end
            default: begin
                n_res_valid = 1'b0;
            end
        endcase
    end

    assign o_busy      = (r_state != ssps_pkg::S_IDLE);
    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

endmodule

[rtl/sorted_sparse_point_set_core.sv]
// Channel   Ports                     Transfer
// command   start, busy, i_item       taken when start is high and busy is low
// result    o_res_valid, o_res        one cycle per item, cannot be held off
//
// Clear and reads of an out-of-range row finish from idle; other reads read the
// row table and, for a column in range, the column memory. Insert binary-searches
// the row table and the row, an issue and a compare state per step; append checks
// the last row and column first. Both shift entries up, a read and a write each.
// Reset is synchronous and empties the set at once; memory contents stay.
// busy is high while an item is at work; results are never stalled.
module sorted_sparse_point_set_core #(
    parameter int MAX_ROWS = ssps_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = ssps_pkg::MAX_COLS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ssps_pkg::t_cmd_item i_item,
    output logic                o_res_valid,
    output ssps_pkg::t_result   o_res
);

    localparam int RAW = $clog2(MAX_ROWS);
    localparam int CAW = $clog2(MAX_COLS);
    localparam int CCW = $clog2(MAX_COLS + 1);
    localparam int RW  = ssps_pkg::KEY_W + CCW + RAW;
    localparam int KW  = ssps_pkg::KEY_W;

    logic               row_we, col_we;
    logic [RAW-1:0]     row_waddr, row_raddr;
    logic [RW-1:0]      row_wdata, row_rdata;
    logic [RAW+CAW-1:0] col_waddr, col_raddr;
    logic [KW-1:0]      col_wdata, col_rdata;

    // Sequencer for search, shifts and results.
    ssps_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (i_item),
        .o_busy      (busy),
        .o_res       (o_res),
        .o_res_valid (o_res_valid),
        .o_row_we    (row_we),
        .o_row_waddr (row_waddr),
        .o_row_wdata (row_wdata),
        .o_row_raddr (row_raddr),
        .i_row_rdata (row_rdata),
        .o_col_we    (col_we),
        .o_col_waddr (col_waddr),
        .o_col_wdata (col_wdata),
        .o_col_raddr (col_raddr),
        .i_col_rdata (col_rdata)
    );

    // Row table: key, point count and column block of each row.
    ssps_ram #(.WIDTH(RW), .DEPTH(MAX_ROWS)) u_row_mem (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    // Column keys, one block per row.
    ssps_ram #(.WIDTH(KW), .DEPTH(MAX_ROWS * (2 ** CAW))) u_col_mem (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (col_waddr),
        .i_wdata (col_wdata),
        .i_raddr (col_raddr),
        .o_rdata (col_rdata)
    );

endmodule

[test/sorted_sparse_point_set_core_test.sv]
module sorted_sparse_point_set_core_test;

    localparam int NROWS = 64;
    localparam int NCOLS = 64;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    ssps_pkg::t_cmd_item i_item;
    logic                o_res_valid;
    ssps_pkg::t_result   o_res;

    sorted_sparse_point_set_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    // Predicted contents of the set, keys in offset binary.
    logic [15:0] pred_row_key [NROWS];
    int          pred_row_cnt [NROWS];
    logic [15:0] pred_col_key [NROWS][NCOLS];
    int          pred_rows;

    ssps_pkg::t_result expected_results [$];
    int                error_count;
    int                item_count;
    int                result_count;
    int                added_count;
    int                full_count;
    bit                allow_idle;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Overall time limit.
    initial begin
        #40000000;
        $display("sorted_sparse_point_set_core verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Checks each result against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) begin
            ssps_pkg::t_result w;
            result_count++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 32'(o_res.status), 32'(0));
            end else begin
                w = expected_results.pop_front();
                if (o_res.status != w.status)
                    report_mismatch("status", 32'(o_res.status), 32'(w.status));
                if (o_res.row_slot != w.row_slot)
                    report_mismatch("row_slot", 32'(o_res.row_slot), 32'(w.row_slot));
                if (o_res.col_slot != w.col_slot)
                    report_mismatch("col_slot", 32'(o_res.col_slot), 32'(w.col_slot));
                if (o_res.row_value != w.row_value)
                    report_mismatch("row_value", 32'(o_res.row_value), 32'(w.row_value));
                if (o_res.col_value != w.col_value)
                    report_mismatch("col_value", 32'(o_res.col_value), 32'(w.col_value));
                if (o_res.points_in_row != w.points_in_row)
                    report_mismatch("points_in_row", 32'(o_res.points_in_row),
                                    32'(w.points_in_row));
                if (o_res.rows_in_use != w.rows_in_use)
                    report_mismatch("rows_in_use", 32'(o_res.rows_in_use),
                                    32'(w.rows_in_use));
            end
        end
    end

    function automatic logic [15:0] as_key(input logic [15:0] c);
        return c ^ 16'h8000;
    endfunction

    // First slot whose row key is not below k.
    function automatic int row_search(input logic [15:0] k);
        int lo = 0;
        int hi = pred_rows;
        int mid;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (pred_row_key[mid] < k) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic int col_search(input int r, input logic [15:0] k);
        int lo = 0;
        int hi = pred_row_cnt[r];
        int mid;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (pred_col_key[r][mid] < k) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic void open_row(input int p, input logic [15:0] k);
        for (int s = pred_rows; s > p; s--) begin
            pred_row_key[s] = pred_row_key[s-1];
            pred_row_cnt[s] = pred_row_cnt[s-1];
            pred_col_key[s] = pred_col_key[s-1];
        end
        pred_row_key[p] = k;
        pred_row_cnt[p] = 0;
        pred_rows++;
    endfunction

    function automatic ssps_pkg::t_result make_result(input ssps_pkg::t_status st,
                                                      input int rs, input int cs,
                                                      input logic [15:0] rv,
                                                      input logic [15:0] cv,
                                                      input int pts);
        ssps_pkg::t_result t;
        t.status        = st;
        t.row_slot      = rs[5:0];
        t.col_slot      = cs[5:0];
        t.row_value     = rv;
        t.col_value     = cv;
        t.points_in_row = pts[6:0];
        t.rows_in_use   = pred_rows[6:0];
        return t;
    endfunction

    // Works out the result of one command and updates the predicted set.
    function automatic ssps_pkg::t_result apply_command(input ssps_pkg::t_cmd_item it);
        logic [15:0] rk = as_key(it.row_coord);
        logic [15:0] ck = as_key(it.col_coord);
        int r, n, c, p;
        if (it.cmd == ssps_pkg::CMD_CLEAR) begin
            pred_rows = 0;
            return make_result(ssps_pkg::ST_ADDED, 0, 0, 0, 0, 0);
        end
        if (it.cmd == ssps_pkg::CMD_READ) begin
            r = it.row_slot_in;
            c = it.col_slot_in;
            if (r >= pred_rows) return make_result(ssps_pkg::ST_EMPTY, r, c, 0, 0, 0);
            n = pred_row_cnt[r];
            if (c >= n)
                return make_result(ssps_pkg::ST_EMPTY, r, c, as_key(pred_row_key[r]), 0, n);
            return make_result(ssps_pkg::ST_ADDED, r, c, as_key(pred_row_key[r]),
                               as_key(pred_col_key[r][c]), n);
        end
        if (it.cmd == ssps_pkg::CMD_APPEND
            && (pred_rows == 0 || rk > pred_row_key[pred_rows-1])) begin
            if (pred_rows >= NROWS)
                return make_result(ssps_pkg::ST_FULL, 0, 0, it.row_coord, it.col_coord, 0);
            open_row(pred_rows, rk);
            r = pred_rows - 1;
        end else begin
            p = row_search(rk);
            if (p < pred_rows && pred_row_key[p] == rk) begin
                r = p;
            end else if (pred_rows >= NROWS) begin
                return make_result(ssps_pkg::ST_FULL, 0, 0, it.row_coord, it.col_coord, 0);
            end else begin
                open_row(p, rk);
                r = p;
            end
        end
        n = pred_row_cnt[r];
        if (it.cmd == ssps_pkg::CMD_APPEND) begin
            if (n != 0 && ck <= pred_col_key[r][n-1])
                return make_result(ssps_pkg::ST_ORDER, r, 0, it.row_coord, it.col_coord, n);
            c = n;
        end else begin
            c = col_search(r, ck);
            if (c < n && pred_col_key[r][c] == ck)
                return make_result(ssps_pkg::ST_PRESENT, r, c, it.row_coord, it.col_coord, n);
        end
        if (n >= NCOLS)
            return make_result(ssps_pkg::ST_FULL, r, 0, it.row_coord, it.col_coord, n);
        for (int s = n; s > c; s--) pred_col_key[r][s] = pred_col_key[r][s-1];
        pred_col_key[r][c] = ck;
        pred_row_cnt[r] = n + 1;
        return make_result(ssps_pkg::ST_ADDED, r, c, it.row_coord, it.col_coord, n + 1);
    endfunction

    // Sends one item, with an optional random idle burst first.
    // start stays high after acceptance so that items can follow without a gap.
    task automatic send_item(input ssps_pkg::t_cmd_item it);
        ssps_pkg::t_result w;
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        w = apply_command(it);
        if (w.status == ssps_pkg::ST_ADDED
            && it.cmd inside {ssps_pkg::CMD_INSERT, ssps_pkg::CMD_APPEND}) added_count++;
        if (w.status == ssps_pkg::ST_FULL) full_count++;
        expected_results.push_back(w);
        item_count++;
    endtask

    task automatic send_cmd(input ssps_pkg::t_cmd c, input logic [15:0] r,
                            input logic [15:0] col, input int rs, input int cs);
        ssps_pkg::t_cmd_item it;
        it.cmd         = c;
        it.row_coord   = r;
        it.col_coord   = col;
        it.row_slot_in = rs[5:0];
        it.col_slot_in = cs[5:0];
        send_item(it);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    // Extremes of coordinates, duplicates, out-of-order appends and empty reads.
    task automatic test_directed();
        send_cmd(ssps_pkg::CMD_READ, 0, 0, 0, 0);
        send_cmd(ssps_pkg::CMD_READ, 0, 0, 63, 63);
        send_cmd(ssps_pkg::CMD_INSERT, 16'h8000, 16'h7FFF, 0, 0);
        send_cmd(ssps_pkg::CMD_INSERT, 16'h7FFF, 16'h8000, 0, 0);
        send_cmd(ssps_pkg::CMD_INSERT, 16'h0000, 16'h0000, 0, 0);
        send_cmd(ssps_pkg::CMD_INSERT, 16'h0000, 16'hFFFF, 0, 0);
        send_cmd(ssps_pkg::CMD_INSERT, 16'h0000, 16'h0000, 0, 0);
        send_cmd(ssps_pkg::CMD_APPEND, 16'h7FFF, 16'h7FFF, 0, 0);
        send_cmd(ssps_pkg::CMD_APPEND, 16'h7FFF, 16'h7FFF, 0, 0);
        send_cmd(ssps_pkg::CMD_APPEND, 16'h0000, 16'h0001, 0, 0);
        send_cmd(ssps_pkg::CMD_APPEND, 16'h0000, 16'hFFFF, 0, 0);
        send_cmd(ssps_pkg::CMD_APPEND, 16'h1234, 16'h5555, 0, 0);
        send_cmd(ssps_pkg::CMD_READ, 0, 0, 1, 0);
        send_cmd(ssps_pkg::CMD_READ, 0, 0, 1, 2);
        send_cmd(ssps_pkg::CMD_READ, 0, 0, 1, 9);
        send_cmd(ssps_pkg::CMD_READ, 0, 0, 3, 1);
        send_cmd(ssps_pkg::CMD_READ, 0, 0, 2, 0);
        send_cmd(ssps_pkg::CMD_READ, 0, 0, 10, 0);
        send_cmd(ssps_pkg::CMD_CLEAR, 16'hAAAA, 16'h5555, 42, 21);
        send_cmd(ssps_pkg::CMD_READ, 0, 0, 0, 0);
    endtask

    // Fills one row to capacity, then the row table, and hits both full cases.
    task automatic test_capacity();
        send_cmd(ssps_pkg::CMD_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < NCOLS; i++)
            send_cmd(ssps_pkg::CMD_APPEND, 16'h0005, 16'(i * 3 - 90), 0, 0);
        send_cmd(ssps_pkg::CMD_APPEND, 16'h0005, 16'h7000, 0, 0);
        send_cmd(ssps_pkg::CMD_INSERT, 16'h0005, 16'h8000, 0, 0);
        send_cmd(ssps_pkg::CMD_INSERT, 16'h0005, 16'(-90), 0, 0);
        send_cmd(ssps_pkg::CMD_READ, 0, 0, 0, 63);
        for (int i = 0; i < NROWS - 1; i++)
            send_cmd(ssps_pkg::CMD_INSERT,
                     16'($urandom_range(0, 3) * 7 + i * 509 - 16000),
                     16'($urandom()), 0, 0);
        send_cmd(ssps_pkg::CMD_INSERT, 16'h7FFF, 16'h0, 0, 0);
        send_cmd(ssps_pkg::CMD_APPEND, 16'h7FFF, 16'h0, 0, 0);
        send_cmd(ssps_pkg::CMD_APPEND, 16'h8000, 16'h0, 0, 0);
        send_cmd(ssps_pkg::CMD_READ, 0, 0, 63, 0);
        // Sender holds off until everything has come back.
        wait_drained();
        send_cmd(ssps_pkg::CMD_INSERT, 16'h0005, 16'h0001, 0, 0);
    endtask

    // Random mix: mostly ordered loads and inserts on a few rows, plus reads.
    task automatic test_random(input int count);
        logic [15:0] base_row;
        logic [15:0] next_col;
        int sel;
        base_row = 16'($urandom());
        next_col = 16'($urandom());
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 2) begin
                send_cmd(ssps_pkg::CMD_CLEAR, 16'($urandom()), 16'($urandom()),
                         $urandom(), $urandom());
            end else if (sel < 30) begin
                if ($urandom_range(0, 7) == 0) base_row = base_row + 16'($urandom_range(1, 300));
                next_col = next_col + 16'($urandom_range(0, 40));
                send_cmd(ssps_pkg::CMD_APPEND, base_row, next_col, $urandom(), $urandom());
            end else if (sel < 60) begin
                send_cmd(ssps_pkg::CMD_INSERT, base_row - 16'($urandom_range(0, 1500)),
                         16'($urandom_range(0, 30)), $urandom(), $urandom());
            end else if (sel < 70) begin
                send_cmd(sel[0] ? ssps_pkg::CMD_INSERT : ssps_pkg::CMD_APPEND,
                         16'($urandom()), 16'($urandom()), $urandom(), $urandom());
            end else begin
                send_cmd(ssps_pkg::CMD_READ, 16'($urandom()), 16'($urandom()),
                         $urandom_range(0, pred_rows + 1), $urandom_range(0, 8));
            end
        end
    endtask

    initial begin
        error_count  = 0;
        item_count   = 0;
        result_count = 0;
        added_count  = 0;
        full_count   = 0;
        pred_rows    = 0;
        allow_idle   = 1'b1;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_item       = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_capacity();
        test_random(350);
        allow_idle = 1'b0;
        test_random(100);
        wait_drained();
        repeat (300) @(posedge i_clk);
        $display("covered %0d commands, %0d results, %0d points added, %0d full cases",
                 item_count, result_count, added_count, full_count);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("sorted_sparse_point_set_core verification clean");
        end else begin
            $display("sorted_sparse_point_set_core verification failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/ssps_pkg.sv
rtl/ssps_ram.sv
rtl/ssps_ctrl.sv
rtl/sorted_sparse_point_set_core.sv
test/sorted_sparse_point_set_core_test.sv
